[rtl/bae_pkg.sv]
// ----------------------------------------------------------------------------
// bae_pkg
// Shared types and constants for the binary arithmetic encoder.
// ----------------------------------------------------------------------------
package bae_pkg;

	// depth of the queue between range update and byte output
	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	// action codes
	localparam logic ActEncode = 1'b0;
	localparam logic ActFlush  = 1'b1;

	// input beat
	typedef struct packed {
		logic        action;
		logic        bit_req;
		logic [15:0] prob;
	} in_item_t;

	// result beat
	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} out_item_t;

	// queued job: bytes to send are the top (cnt + 1) bytes of word
	typedef struct packed {
		logic [31:0] word;
		logic [1:0]  cnt;
	} bae_entry_t;

endpackage

[rtl/binary_arithmetic_encoder.sv]
// ----------------------------------------------------------------------------
// binary_arithmetic_encoder
// Carry-less 32-bit binary arithmetic encoder with flush.
// ----------------------------------------------------------------------------
// an item's bytes pass the update stage registers and the job queue to the ports;
// a new item is taken only once the last leaves the update stage, as the multiply
//   then interval update path holds the range registers; bytes drain one per cycle
//   while pop is high, from a 4-deep queue; full is high while an item is in update
// reset: interval goes to [0, 0xffffffff], queue empty, no item in flight
module binary_arithmetic_encoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  bae_pkg::in_item_t  cmd,
	input  logic               pop,
	output logic               empty,
	output bae_pkg::out_item_t res
);
	import bae_pkg::*;

	logic       q_full;
	logic       q_push;
	bae_entry_t q_entry;
	bae_entry_t q_head;
	logic       q_empty;
	logic       q_pop;

	// interval update
	bae_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.cmd     (cmd),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_entry (q_entry)
	);

	// job queue
	bae_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_entry),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_head),
		.empty   (q_empty)
	);

	// byte output
	bae_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.head_empty (q_empty),
		.head_pop   (q_pop),
		.pop        (pop),
		.empty      (empty),
		.res        (res)
	);

endmodule

[rtl/bae_front.sv]
// ----------------------------------------------------------------------------
// bae_front
// Takes input beats, splits the coding interval, shifts out agreeing bytes
// and hands the byte jobs to the queue.
// ----------------------------------------------------------------------------
module bae_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  bae_pkg::in_item_t   cmd,
	input  logic                q_full,
	output logic                q_push,
	output bae_pkg::bae_entry_t q_entry
);
	import bae_pkg::*;

	logic [31:0] low_q;
	logic [31:0] high_q;
	logic        busy_q;
	logic        flush_s1;
	logic        bit_s1;
	logic [31:0] hi_s1;
	logic [15:0] lo_s1;

	logic        accept;
	logic [31:0] range_w;
	logic [31:0] lo_prod;
	logic [31:0] mid;
	logic [31:0] new_low;
	logic [31:0] new_high;
	logic [31:0] diff;
	logic        a0, a1, a2, a3;
	logic [2:0]  n_shift;
	logic [31:0] low_next;
	logic [31:0] high_next;
	logic        need_push;
	logic        advance;

	assign full    = busy_q;
	assign accept  = push && !busy_q;

	// interval width and partial products from the current state
	assign range_w = high_q - low_q;
	assign lo_prod = {16'h0, range_w[15:0]} * {16'h0, cmd.prob};

	always_ff @(posedge clk) begin
		if (accept) begin
			flush_s1 <= (cmd.action == ActFlush);
			bit_s1   <= cmd.bit_req;
			hi_s1    <= {16'h0, range_w[31:16]} * {16'h0, cmd.prob};
			lo_s1    <= lo_prod[31:16];
		end
	end

	// split point and new interval
	always_comb begin
		mid = low_q + hi_s1 + {16'h0, lo_s1};
		new_low  = low_q;
		new_high = high_q;
		if (!flush_s1) begin
			if (bit_s1) begin
				new_high = mid;
			end else begin
				new_low = mid + 32'd1;
			end
		end
	end

	// count leading bytes on which low and high agree
	assign diff = new_low ^ new_high;
	assign a0 = (diff[31:24] == 8'h00);
	assign a1 = a0 && (diff[23:16] == 8'h00);
	assign a2 = a1 && (diff[15:8] == 8'h00);
	assign a3 = a2 && (diff[7:0] == 8'h00) && !flush_s1;

	always_comb begin
		if (a3) begin
			n_shift = 3'd4;
		end else if (a2) begin
			n_shift = 3'd3;
		end else if (a1) begin
			n_shift = 3'd2;
		end else if (a0) begin
			n_shift = 3'd1;
		end else begin
			n_shift = 3'd0;
		end
	end

	// byte shift of the interval
	always_comb begin
		case (n_shift)
			3'd0: begin
				low_next  = new_low;
				high_next = new_high;
			end
			3'd1: begin
				low_next  = {new_low[23:0], 8'h00};
				high_next = {new_high[23:0], 8'hff};
			end
			3'd2: begin
				low_next  = {new_low[15:0], 16'h0000};
				high_next = {new_high[15:0], 16'hffff};
			end
			3'd3: begin
				low_next  = {new_low[7:0], 24'h000000};
				high_next = {new_high[7:0], 24'hffffff};
			end
			default: begin
				low_next  = 32'h0000_0000;
				high_next = 32'hffff_ffff;
			end
		endcase
	end

	// job for the byte side: flush sends one byte past the agreeing ones
	always_comb begin
		q_entry.word = new_high;
		if (flush_s1) begin
			need_push    = 1'b1;
			q_entry.cnt  = n_shift[1:0];
		end else begin
			need_push    = (n_shift != 3'd0);
			q_entry.cnt  = 2'(n_shift - 3'd1);
		end
	end

	assign advance = busy_q && (!need_push || !q_full);
	assign q_push  = busy_q && need_push && !q_full;

	// interval registers and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= 32'h0000_0000;
			high_q <= 32'hffff_ffff;
			busy_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (advance) begin
				busy_q <= 1'b0;
				low_q  <= low_next;
				high_q <= high_next;
			end
		end
	end

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q)
		else $error("accepted beat did not occupy the update stage");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("job pushed into a full queue");

	a_flush_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && flush_s1 && !q_full |-> q_push)
		else $error("flush retired without a byte");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !advance |=> busy_q && $stable(low_q) && $stable(high_q))
		else $error("interval changed while update stalled");

endmodule

[rtl/bae_fifo.sv]
// ----------------------------------------------------------------------------
// bae_fifo
// Small job queue between the range update and the byte output.
// ----------------------------------------------------------------------------
module bae_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  bae_pkg::bae_entry_t wr_data,
	output logic                full,
	input  logic                rd_en,
	output bae_pkg::bae_entry_t rd_data,
	output logic                empty
);
	import bae_pkg::*;

	bae_entry_t       mem_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == QCntW'(QDepth));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + QPtrW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + QPtrW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + QCntW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - QCntW'(1);
			end
		end
	end

endmodule

[rtl/bae_back.sv]
// ----------------------------------------------------------------------------
// bae_back
// Walks the head job of the queue and presents its bytes one beat at a time.
// ----------------------------------------------------------------------------
module bae_back (
	input  logic                clk,
	input  logic                arst_n,
	input  bae_pkg::bae_entry_t head,
	input  logic                head_empty,
	output logic                head_pop,
	input  logic                pop,
	output logic                empty,
	output bae_pkg::out_item_t  res
);
	import bae_pkg::*;

	logic [1:0] idx_q;
	logic       take;
	logic       at_last;

	assign empty   = head_empty;
	assign take    = pop && !head_empty;
	assign at_last = (idx_q == head.cnt);
	assign head_pop = take && at_last;

	// byte select, most significant first
	always_comb begin
		case (idx_q)
			2'd0:    res.out_byte = head.word[31:24];
			2'd1:    res.out_byte = head.word[23:16];
			2'd2:    res.out_byte = head.word[15:8];
			default: res.out_byte = head.word[7:0];
		endcase
		res.last = at_last;
	end

	// position inside the head job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (take) begin
			if (at_last) begin
				idx_q <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule
